>>> design/eeq_pkg.sv
// Package for the expiry event queue: sizes, operation and status codes,
// and the slot, request, compare and result types. Depends on nothing.
package eeq_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int LEASE_ID_BITS = 16;

    localparam int ADDR_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int CLOCK_W   = 64;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 7;
    localparam int LEASE_W   = 16;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY_POP = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic [CLOCK_W-1:0]       clock;
        logic [LEASE_ID_BITS-1:0] lease;
    } slot_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        slot_t             key;
    } req_t;

    typedef struct packed {
        logic lease_eq;
        logic clock_eq;
        logic clock_gt;
    } cmp_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                is_empty;
        logic [COUNT_W-1:0]  entry_count;
        logic [CLOCK_W-1:0]  front_clock;
        logic [LEASE_W-1:0]  front_lease;
    } result_t;

endpackage

>>> design/eeq_in_if.sv
// Request channel of the expiry event queue: valid, ready and one operation.
// Depends on eeq_pkg.
interface eeq_in_if import eeq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [CLOCK_W-1:0]  expiry_clock;
    logic [LEASE_W-1:0]  lease_id;

    modport source (output valid, kind, expiry_clock, lease_id, input ready);
    modport sink   (input valid, kind, expiry_clock, lease_id, output ready);
endinterface

>>> design/eeq_out_if.sv
// Response channel of the expiry event queue: valid, ready and one result.
// Depends on eeq_pkg.
interface eeq_out_if import eeq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                is_empty;
    logic [COUNT_W-1:0]  entry_count;
    logic [CLOCK_W-1:0]  front_clock;
    logic [LEASE_W-1:0]  front_lease;

    modport source (output valid, status, is_empty, entry_count, front_clock, front_lease,
                    input ready);
    modport sink   (input valid, status, is_empty, entry_count, front_clock, front_lease,
                    output ready);
endinterface

>>> design/eeq_store.sv
// Slot memory of the expiry event queue: one write port, one registered read.
// Depends on eeq_pkg.
module eeq_store import eeq_pkg::*;
(
    input  logic  clk,
    input  logic  wr_en,
    input  addr_t wr_addr,
    input  slot_t wr_data,
    input  addr_t rd_addr,
    output slot_t rd_data
);

    slot_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/eeq_cmp.sv
// Shared compare unit: matches one stored slot against the search key.
// Depends on eeq_pkg.
module eeq_cmp import eeq_pkg::*;
(
    input  slot_t entry,
    input  slot_t key,
    output cmp_t  res
);

    assign res.lease_eq = (entry.lease == key.lease);
    assign res.clock_eq = (entry.clock == key.clock);
    assign res.clock_gt = (entry.clock >  key.clock);

endmodule

>>> design/eeq_seq.sv
// Sequencer of the expiry event queue: scans, shifts and reads the front slot
// through the slot memory and the shared compare unit. Depends on eeq_pkg,
// eeq_store and eeq_cmp.
module eeq_seq import eeq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  req_t    req,
    output logic    idle,
    input  logic    out_free,
    output logic    res_load,
    output result_t res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHUP  = 3'd2;
    localparam logic [2:0] S_SHDN  = 3'd3;
    localparam logic [2:0] S_FRONT = 3'd4;
    localparam logic [2:0] S_LOAD  = 3'd5;

    logic [2:0]          state_reg, state_next;
    cnt_t                idx_reg, idx_next;
    cnt_t                pos_reg, pos_next;
    cnt_t                count_reg, count_next;
    logic                found_reg, found_next;
    logic                dup_reg, dup_next;
    logic                pend_reg, pend_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    slot_t               key_reg, key_next;

    logic  wr_en;
    addr_t wr_addr;
    slot_t wr_data;
    addr_t rd_addr;
    slot_t rd_data;
    cmp_t  cmp;
    cnt_t  idx_m1;
    cnt_t  idx_p1;

    eeq_store u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    eeq_cmp u_cmp
    (
        .entry (rd_data),
        .key   (key_reg),
        .res   (cmp)
    );

    assign idx_m1 = idx_reg - 1'b1;
    assign idx_p1 = idx_reg + 1'b1;
    assign idle   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        found_next  = found_reg;
        dup_next    = dup_reg;
        pend_next   = 1'b0;
        status_next = status_reg;
        kind_next   = kind_reg;
        key_next    = key_reg;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = rd_data;
        res_load    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next   = req.kind;
                    key_next    = req.key;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    dup_next    = 1'b0;
                    status_next = ST_OK;
                    unique case (req.kind)
                        KIND_INSERT, KIND_REMOVE:
                        begin
                            state_next = S_SCAN;
                        end
                        KIND_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY_POP;
                                state_next  = S_FRONT;
                            end
                            else
                            begin
                                pos_next   = '0;
                                state_next = S_SHDN;
                            end
                        end
                        default:
                        begin
                            state_next = S_FRONT;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // The slot read last cycle sits at idx - 1.
                if (pend_reg)
                begin
                    dup_next = dup_reg | cmp.lease_eq;
                    if (!found_reg)
                    begin
                        if ((kind_reg == KIND_INSERT && cmp.clock_gt) ||
                            (kind_reg == KIND_REMOVE && cmp.clock_eq && cmp.lease_eq))
                        begin
                            found_next = 1'b1;
                            pos_next   = idx_m1;
                        end
                    end
                end
                if (idx_reg < count_reg)
                begin
                    rd_addr   = idx_reg[ADDR_W-1:0];
                    pend_next = 1'b1;
                    idx_next  = idx_p1;
                end
                else if (!pend_reg)
                begin
                    if (kind_reg == KIND_INSERT)
                    begin
                        if (dup_reg)
                        begin
                            status_next = ST_DUPLICATE;
                            state_next  = S_FRONT;
                        end
                        else if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FRONT;
                        end
                        else
                        begin
                            if (!found_reg)
                            begin
                                pos_next = count_reg;
                            end
                            idx_next   = count_reg;
                            state_next = S_SHUP;
                        end
                    end
                    else
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_FRONT;
                        end
                        else
                        begin
                            idx_next   = pos_reg;
                            state_next = S_SHDN;
                        end
                    end
                end
            end

            S_SHUP:
            begin
                // Move slots up by one from the top down to the insert point.
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_p1[ADDR_W-1:0];
                    wr_data = rd_data;
                end
                if (idx_reg > pos_reg)
                begin
                    rd_addr   = idx_m1[ADDR_W-1:0];
                    pend_next = 1'b1;
                    idx_next  = idx_m1;
                end
                else if (!pend_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[ADDR_W-1:0];
                    wr_data    = key_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_FRONT;
                end
            end

            S_SHDN:
            begin
                // Close the gap at the removed slot, moving later slots down.
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_m1[ADDR_W-1:0];
                    wr_data = rd_data;
                end
                if (idx_p1 < count_reg)
                begin
                    rd_addr   = idx_p1[ADDR_W-1:0];
                    pend_next = 1'b1;
                    idx_next  = idx_p1;
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_FRONT;
                end
            end

            S_FRONT:
            begin
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status      = status_reg;
        res.is_empty    = (count_reg == '0);
        res.entry_count = COUNT_W'(count_reg);
        if (count_reg == '0)
        begin
            res.front_clock = '0;
            res.front_lease = '0;
        end
        else
        begin
            res.front_clock = rd_data.clock;
            res.front_lease = LEASE_W'(rd_data.lease);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        dup_reg    <= dup_next;
        status_reg <= status_next;
        kind_reg   <= kind_next;
        key_reg    <= key_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("stored count exceeds queue depth");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> CNT_W'(wr_addr) <= count_reg)
        else $error("slot write beyond the occupied range");

    a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHUP) |-> count_reg < CNT_W'(QUEUE_DEPTH))
        else $error("insert shift started on a full store");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result loaded while output register is occupied");

endmodule

>>> design/expiry_event_queue.sv
// Expiry event queue: holds up to QUEUE_DEPTH lease expiry events sorted by
// expiry clock, equal clocks in insertion order, in a slot memory with one
// write port and one read port, walked by a sequencer with one shared 64-bit
// compare unit. Each request transfer is one operation (insert, pop earliest,
// remove by clock and lease id; the unused kind changes nothing) and yields
// exactly one response transfer carrying the status, the emptiness flag, the
// entry count and the front event. An insert or remove first scans the stored
// events (duplicate and position search); an insert then shifts the slots from
// the insert point up and writes the new event, a remove shifts the later slots
// down, and a pop shifts every other slot down. Every operation then reads the
// front slot, waiting while the output register is still held. A refused
// operation skips the shift; an empty pop skips the scan as well. The read port
// delivers one slot per cycle. Request ready is high only while the sequencer
// is idle, and a finished result waits in an output register, so a new request
// can be taken while the last response is still pending. Depends on eeq_pkg,
// eeq_in_if, eeq_out_if and eeq_seq.
module expiry_event_queue import eeq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    eeq_in_if.sink      request,
    eeq_out_if.source   response
);

    logic    start;
    logic    idle;
    logic    out_free;
    logic    res_load;
    req_t    req;
    result_t res;

    logic    out_vld_reg;
    result_t res_reg;

    // Only the low LEASE_ID_BITS of the lease id take part in matching.
    assign req.kind      = request.kind;
    assign req.key.clock = request.expiry_clock;
    assign req.key.lease = LEASE_ID_BITS'(32'(request.lease_id));

    assign request.ready = idle;
    assign start         = request.valid && idle;

    // The output register is free when empty or when its transfer completes now.
    assign out_free = !out_vld_reg || response.ready;

    eeq_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .idle     (idle),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (response.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign response.valid       = out_vld_reg;
    assign response.status      = res_reg.status;
    assign response.is_empty    = res_reg.is_empty;
    assign response.entry_count = res_reg.entry_count;
    assign response.front_clock = res_reg.front_clock;
    assign response.front_lease = res_reg.front_lease;

endmodule

>>> tb/sv/eeq_queue_checker.sv
// Response checker for the expiry event queue: keeps its own sorted event store,
// predicts one response per request transfer and compares every response field.
// Depends on eeq_pkg, eeq_in_if and eeq_out_if.
module eeq_queue_checker import eeq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    eeq_in_if    request,
    eeq_out_if   response,
    output int   error_count,
    output int   outstanding
);

    logic [CLOCK_W-1:0]       held_clock [QUEUE_DEPTH];
    logic [LEASE_ID_BITS-1:0] held_lease [QUEUE_DEPTH];
    int                       held_count;
    result_t                  predicted_results [$];
    result_t                  oldest;

    function automatic void drop_entry(input int pos);
        for (int i = pos; i + 1 < held_count; i++)
        begin
            held_clock[i] = held_clock[i + 1];
            held_lease[i] = held_lease[i + 1];
        end
        held_count--;
    endfunction

    // Applies one operation to the shadow store and returns the response it implies.
    function automatic result_t apply_operation(input logic [KIND_W-1:0]  kind,
                                                input logic [CLOCK_W-1:0] clock,
                                                input logic [LEASE_W-1:0] lease_in);
        logic [LEASE_ID_BITS-1:0] lease;
        logic [STATUS_W-1:0]      status;
        int                       pos;
        bit                       found;
        result_t                  res;
        lease  = lease_in[LEASE_ID_BITS-1:0];
        status = ST_OK;
        found  = 1'b0;
        pos    = 0;
        case (kind)
            KIND_INSERT:
            begin
                for (int i = 0; i < held_count; i++)
                begin
                    if (held_lease[i] == lease)
                        found = 1'b1;
                end
                if (found)
                    status = ST_DUPLICATE;
                else if (held_count >= QUEUE_DEPTH)
                    status = ST_FULL;
                else
                begin
                    // Equal clocks keep insertion order: skip past every clock <= new one.
                    while (pos < held_count && held_clock[pos] <= clock)
                        pos++;
                    for (int i = held_count; i > pos; i--)
                    begin
                        held_clock[i] = held_clock[i - 1];
                        held_lease[i] = held_lease[i - 1];
                    end
                    held_clock[pos] = clock;
                    held_lease[pos] = lease;
                    held_count++;
                end
            end
            KIND_POP:
            begin
                if (held_count == 0)
                    status = ST_EMPTY_POP;
                else
                    drop_entry(0);
            end
            KIND_REMOVE:
            begin
                pos = -1;
                for (int i = 0; i < held_count; i++)
                begin
                    if (pos < 0 && held_clock[i] == clock && held_lease[i] == lease)
                        pos = i;
                end
                if (pos < 0)
                    status = ST_NOT_FOUND;
                else
                    drop_entry(pos);
            end
            default:
            begin
                // The unused kind leaves the store alone and reports it as it is.
            end
        endcase
        res.status      = status;
        res.is_empty    = (held_count == 0);
        res.entry_count = COUNT_W'(held_count);
        res.front_clock = (held_count == 0) ? '0 : held_clock[0];
        res.front_lease = (held_count == 0) ? '0 : LEASE_W'(held_lease[0]);
        return res;
    endfunction

    task automatic compare_field(input string              field_name,
                                 input logic [CLOCK_W-1:0] want,
                                 input logic [CLOCK_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field_name, want, got);
            error_count++;
        end
    endtask

    // Responses are handled before requests; a response never belongs to a
    // request taken on the same edge, so the order only keeps the queue tidy.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            predicted_results.delete();
            error_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (response.valid && response.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual status %0h",
                             $time, response.status);
                    error_count++;
                end
                else
                begin
                    oldest = predicted_results[0];
                    predicted_results.delete(0);
                    compare_field("status", oldest.status, response.status);
                    compare_field("is_empty", oldest.is_empty, response.is_empty);
                    compare_field("entry_count", oldest.entry_count, response.entry_count);
                    compare_field("front_clock", oldest.front_clock, response.front_clock);
                    compare_field("front_lease", oldest.front_lease, response.front_lease);
                end
            end
            if (request.valid && request.ready)
                predicted_results.push_back(apply_operation(request.kind,
                                                            request.expiry_clock,
                                                            request.lease_id));
            outstanding <= predicted_results.size();
        end
    end

endmodule

>>> tb/sv/tb_expiry_event_queue.sv
// Testbench top for the expiry event queue: clock, reset, request stimulus,
// response back-pressure and the final verdict. Checking lives in eeq_queue_checker.
// Depends on eeq_pkg, eeq_in_if, eeq_out_if, eeq_queue_checker and expiry_event_queue.
module tb_expiry_event_queue;
    import eeq_pkg::*;

    // Kind 3 is not an operation; the block must answer it with the store unchanged.
    localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
    localparam logic [CLOCK_W-1:0] CLOCK_MAX   = '1;

    // Random traffic runs in phases of one mix each. A fill phase drives the
    // store to full, a drain phase empties it, a balanced phase churns it.
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

    localparam int PHASE_COUNT = 12;
    localparam int PHASE_ITEMS = 100;
    // A full insert or remove walks the store about twice; the tail after the
    // last response covers that.
    localparam int TAIL_CYCLES = 200;
    // The response side holds ready low this long twice in the run, so the
    // output register fills and the block stops taking requests.
    localparam int LONG_HOLD   = 600;
    // The slowest correct run is about 1250 transfers plus the long holds;
    // this bound leaves several times that.
    localparam int CYCLE_LIMIT = 1000000;

    logic clk;
    logic rst_n;
    int   check_failures;
    int   results_pending;
    int   cycle_count;
    bit   steady_flow;
    slot_t issued_keys [$];

    eeq_in_if  request_ch ();
    eeq_out_if response_ch ();

    expiry_event_queue u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    eeq_queue_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request_ch),
        .response    (response_ch),
        .error_count (check_failures),
        .outstanding (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost response ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL expiry_event_queue");
            $finish;
        end
    end

    // Clocks: one in four a small value so that equal clocks meet often, the rest
    // from the full range, the top end and the low 32 bits, so that every bit toggles.
    function automatic logic [CLOCK_W-1:0] pick_clock();
        case ($urandom_range(0, 3))
            0:       return CLOCK_W'($urandom_range(0, 15));
            1:       return {$urandom, $urandom};
            2:       return CLOCK_MAX - CLOCK_W'($urandom_range(0, 15));
            default: return {32'h0, $urandom};
        endcase
    endfunction

    // Half of the lease ids come from a small pool, so duplicates are common;
    // the rest are fresh 16-bit values, which lets the store actually fill.
    function automatic logic [LEASE_W-1:0] pick_lease();
        if ($urandom_range(0, 1) == 0)
            return LEASE_W'($urandom_range(0, 95));
        return LEASE_W'($urandom);
    endfunction

    function automatic logic [KIND_W-1:0] choose_kind(input mix_t mix);
        int roll;
        int insert_pct;
        int pop_pct;
        int remove_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
            begin
                insert_pct = 80;
                pop_pct    = 8;
                remove_pct = 8;
            end
            MIX_DRAIN:
            begin
                insert_pct = 15;
                pop_pct    = 55;
                remove_pct = 25;
            end
            default:
            begin
                insert_pct = 45;
                pop_pct    = 25;
                remove_pct = 25;
            end
        endcase
        if (roll < insert_pct)
            return KIND_INSERT;
        if (roll < insert_pct + pop_pct)
            return KIND_POP;
        if (roll < insert_pct + pop_pct + remove_pct)
            return KIND_REMOVE;
        return KIND_UNUSED;
    endfunction

    // Offers one operation and returns on the edge where it is transferred.
    // Valid is only lowered when a gap precedes the item, so back-to-back
    // items keep valid high without a second assignment in the same step.
    task automatic offer(input logic [KIND_W-1:0]  kind,
                         input logic [CLOCK_W-1:0] clock,
                         input logic [LEASE_W-1:0] lease);
        int    gap;
        slot_t key;
        gap = steady_flow ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_ch.valid        <= 1'b1;
        request_ch.kind         <= kind;
        request_ch.expiry_clock <= clock;
        request_ch.lease_id     <= lease;
        do
            @(posedge clk);
        while (request_ch.ready !== 1'b1);
        // Remember inserted keys so that later removes mostly name real events.
        if (kind == KIND_INSERT)
        begin
            key.clock = clock;
            key.lease = lease[LEASE_ID_BITS-1:0];
            issued_keys.push_back(key);
            if (issued_keys.size() > 128)
                issued_keys.delete(0);
        end
    endtask

    // Stops offering and waits until the checker has seen every response.
    // The first edge is always taken so that a push made on this edge counts.
    task automatic wait_drained();
        request_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_pending != 0);
    endtask

    // Response side: random stalls per transfer, none in steady phases, and
    // two long holds counted here while the request side keeps offering.
    initial
    begin : responder
        int stall;
        int taken;
        taken = 0;
        response_ch.ready <= 1'b0;
        do
            @(posedge clk);
        while (rst_n !== 1'b1);
        forever
        begin
            if (taken == 200 || taken == 800)
                stall = LONG_HOLD;
            else if (steady_flow)
                stall = 0;
            else
                stall = $urandom_range(0, 7);
            if (stall > 0)
            begin
                response_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            response_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (response_ch.valid !== 1'b1);
            taken++;
        end
    end

    initial
    begin : stimulus
        logic [KIND_W-1:0]  kind;
        logic [CLOCK_W-1:0] clock;
        logic [LEASE_W-1:0] lease;
        slot_t              key;
        mix_t               mix;

        cycle_count              <= 0;
        steady_flow               = 1'b0;
        rst_n                    <= 1'b0;
        request_ch.valid         <= 1'b0;
        request_ch.kind          <= KIND_INSERT;
        request_ch.expiry_clock  <= '0;
        request_ch.lease_id      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An empty store first: empty pop, missing remove and
        // the unused kind, all with zero front fields.
        offer(KIND_POP, '0, '0);
        offer(KIND_REMOVE, '0, '0);
        offer(KIND_UNUSED, CLOCK_MAX, 16'hFFFF);
        // Extreme clocks and leases, then a duplicate lease with another clock.
        offer(KIND_INSERT, CLOCK_MAX, 16'hFFFF);
        offer(KIND_INSERT, '0, 16'h0000);
        offer(KIND_INSERT, 64'd7, 16'h0000);
        // Three events with one clock must leave in insertion order; the fourth is a duplicate.
        offer(KIND_INSERT, 64'd5, 16'h0001);
        offer(KIND_INSERT, 64'd5, 16'h0002);
        offer(KIND_INSERT, 64'd5, 16'h0003);
        offer(KIND_INSERT, 64'd5, 16'hFFFF);
        // Remove from the middle of a tie, then two near misses: right lease
        // with the wrong clock, right clock with the wrong lease.
        offer(KIND_REMOVE, 64'd5, 16'h0002);
        offer(KIND_REMOVE, 64'd6, 16'h0003);
        offer(KIND_REMOVE, 64'd5, 16'h0009);
        offer(KIND_UNUSED, 64'h1234_5678_9ABC_DEF0, 16'h5A5A);
        offer(KIND_POP, '0, '0);
        offer(KIND_POP, CLOCK_MAX, 16'hFFFF);
        // Removing the last event in the store.
        offer(KIND_REMOVE, CLOCK_MAX, 16'hFFFF);
        offer(KIND_INSERT, 64'h8000_0000_0000_0000, 16'h8000);
        offer(KIND_INSERT, 64'h5555_5555_5555_5555, 16'h5555);
        offer(KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA);
        repeat (4)
            offer(KIND_POP, '0, '0);
        offer(KIND_POP, '0, '0);
        wait_drained();

        // Random part: fill, fill again into the full store, drain, then a
        // balanced phase with no idling on either side.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase % 4)
                0, 1:    mix = MIX_FILL;
                2:       mix = MIX_DRAIN;
                default: mix = MIX_BALANCED;
            endcase
            steady_flow = (phase % 4 == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                kind  = choose_kind(mix);
                clock = pick_clock();
                lease = pick_lease();
                if (kind == KIND_REMOVE && issued_keys.size() != 0 &&
                    $urandom_range(0, 3) != 0)
                begin
                    key   = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
                    clock = key.clock;
                    lease = LEASE_W'(key.lease);
                    // Now and then a key that differs in one lease bit.
                    if ($urandom_range(0, 5) == 0)
                        lease = lease ^ LEASE_W'(1);
                end
                offer(kind, clock, lease);
            end
            steady_flow = 1'b0;
            if (phase % 2 == 1)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (check_failures == 0)
            $display("PASS expiry_event_queue");
        else
            $display("FAIL expiry_event_queue");
        $finish;
    end

endmodule

>>> files.f
design/eeq_pkg.sv
design/eeq_in_if.sv
design/eeq_out_if.sv
design/eeq_store.sv
design/eeq_cmp.sv
design/eeq_seq.sv
design/expiry_event_queue.sv
tb/sv/eeq_queue_checker.sv
tb/sv/tb_expiry_event_queue.sv
